[sv/atu_pkg.sv]
package atu_pkg;

    localparam int NSQ    = 32;
    localparam int NNRM   = 6;
    localparam int NCOR   = 28;
    localparam int ST_SQ  = 2;
    localparam int ST_NRM = ST_SQ + NSQ;
    localparam int ST_COR = ST_NRM + NNRM;
    localparam int NST    = ST_COR + NCOR;
    localparam int ANG90  = 23040;

    // atan(2^-i) in degrees, Q.24
    localparam logic signed [31:0] ATAN_T [0:NCOR-1] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934, 32'sd30029717, 32'sd15018523, 32'sd7509720,
        32'sd3754917, 32'sd1877466, 32'sd938734, 32'sd469367, 32'sd234684,
        32'sd117342, 32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334,
        32'sd3667, 32'sd1833, 32'sd917, 32'sd458, 32'sd229,
        32'sd115, 32'sd57, 32'sd29, 32'sd14, 32'sd7
    };

    typedef struct packed {
        logic        neg;
        logic        nzero;
        logic        szero;
        logic [15:0] an;
    } t_lane;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
        logic [31:0] rad;
    } t_sq;

    typedef struct packed {
        logic [59:0] m;
        logic [59:0] v;
    } t_nrm;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [31:0] acc;
    } t_cor;

    typedef struct packed {
        logic signed [15:0] roll_deg;
        logic signed [15:0] pitch_deg;
    } t_res;

    // one restoring square-root digit
    function automatic t_sq sq_step(input t_sq a);
        t_sq         o;
        logic [34:0] rem2;
        logic [34:0] trial;
        rem2  = {a.rem[32:0], a.rad[31:30]};
        trial = {1'b0, a.root, 2'b01};
        o.rad = {a.rad[29:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {a.root[30:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {a.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // shift both words left by k if the top k bits of both are clear
    function automatic t_nrm nrm_step(input t_nrm a, input int k);
        t_nrm        o;
        logic [59:0] both;
        both = a.m | a.v;
        o    = a;
        if ((both >> (60 - k)) == 60'd0) begin
            o.m = a.m << k;
            o.v = a.v << k;
        end
        return o;
    endfunction

    // one CORDIC vectoring rotation
    function automatic t_cor cor_step(input t_cor a, input int i);
        t_cor               o;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (!a.y[63]) begin
            o.x   = a.x + dx;
            o.y   = a.y - dy;
            o.acc = a.acc + ATAN_T[i];
        end else begin
            o.x   = a.x - dx;
            o.y   = a.y + dy;
            o.acc = a.acc - ATAN_T[i];
        end
        return o;
    endfunction

endpackage

[sv/atu_in_if.sv]
interface atu_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;

    modport source (output valid, output acc_x, output acc_y, output acc_z, input ready);
    modport sink   (input valid, input acc_x, input acc_y, input acc_z, output ready);
endinterface

interface atu_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;

    modport source (output valid, output roll_deg, output pitch_deg, input ready);
    modport sink   (input valid, input roll_deg, input pitch_deg, output ready);
endinterface

[sv/accel_tilt_angles_unit.sv]
// Tilt angles from one three-axis accelerometer sample: roll = atan2(y, |x,z|)
// and pitch = -atan2(x, |y,z|), in signed Q8.8 degrees. One sample enters per
// clock; the pipeline runs through the 2 squaring/summing stages, the
// 32-stage square root (one root bit per stage), 6 normalizing shift stages
// and 28 CORDIC stages, with the last stage feeding the output queue
// directly. A two-entry output queue lets the pipeline keep taking samples
// while a result waits; the pipeline freezes only when that queue is full.
module accel_tilt_angles_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    atu_in_if.sink    i_in,
    atu_out_if.source o_out
);
    import atu_pkg::*;

    logic             ce;
    logic [NST-1:0]   r_vld;
    t_lane            r_side [0:NST-1][0:1];
    logic [30:0]      r_xx, r_yy, r_zz;
    logic [31:0]      r_sum  [0:1];
    t_sq              r_sq   [0:NSQ-1][0:1];
    t_nrm             r_nm   [0:NNRM-1][0:1];
    t_cor             r_co   [0:NCOR-1][0:1];
    t_res             r_q0, r_q1, n_res;
    logic [1:0]       r_cnt;
    logic             push, pop;
    logic [15:0]      ang [0:1];
    t_lane            s0 [0:1];
    logic signed [31:0] px, py, pz;

    assign ce         = (r_cnt != 2'd2);
    assign i_in.ready = ce;

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    // per-lane flags from the raw sample; lane 0 is roll, lane 1 is pitch
    always_comb begin
        s0[0].neg   = i_in.acc_y[15];
        s0[0].nzero = (i_in.acc_y == 16'sd0);
        s0[0].szero = (i_in.acc_x == 16'sd0) && (i_in.acc_z == 16'sd0);
        s0[0].an    = i_in.acc_y[15] ? (~i_in.acc_y + 16'd1) : i_in.acc_y;
        s0[1].neg   = i_in.acc_x[15];
        s0[1].nzero = (i_in.acc_x == 16'sd0);
        s0[1].szero = (i_in.acc_y == 16'sd0) && (i_in.acc_z == 16'sd0);
        s0[1].an    = i_in.acc_x[15] ? (~i_in.acc_x + 16'd1) : i_in.acc_x;
        px          = i_in.acc_x * i_in.acc_x;
        py          = i_in.acc_y * i_in.acc_y;
        pz          = i_in.acc_z * i_in.acc_z;
    end

    // square the axes, then form both sums
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_xx        <= px[30:0];
            r_yy        <= py[30:0];
            r_zz        <= pz[30:0];
            r_side[0][0] <= s0[0];
            r_side[0][1] <= s0[1];
            r_sum[0]    <= {1'b0, r_xx} + {1'b0, r_zz};
            r_sum[1]    <= {1'b0, r_yy} + {1'b0, r_zz};
            r_side[1]   <= r_side[0];
        end
    end

    genvar k, l;
    generate
        for (k = 2; k < NST; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end

        for (l = 0; l < 2; l++) begin : g_lane
            // square root of sum * 2^32, one root bit per stage
            for (k = 0; k < NSQ; k++) begin : g_sq
                if (k == 0) begin : g_first
                    always_ff @(posedge i_clk) begin
                        if (ce) begin
                            r_sq[0][l] <= sq_step('{rem: 35'd0, root: 32'd0, rad: r_sum[l]});
                        end
                    end
                end else begin : g_rest
                    always_ff @(posedge i_clk) begin
                        if (ce) begin
                            r_sq[k][l] <= sq_step(r_sq[k-1][l]);
                        end
                    end
                end
            end

            // normalize magnitude and numerator together
            for (k = 0; k < NNRM; k++) begin : g_nrm
                if (k == 0) begin : g_first
                    always_ff @(posedge i_clk) begin
                        if (ce) begin
                            r_nm[0][l] <= nrm_step('{
                                m: {28'd0, r_sq[NSQ-1][l].root},
                                v: {28'd0, r_side[ST_NRM-1][l].an, 16'd0}},
                                32 >> k);
                        end
                    end
                end else begin : g_rest
                    always_ff @(posedge i_clk) begin
                        if (ce) begin
                            r_nm[k][l] <= nrm_step(r_nm[k-1][l], 32 >> k);
                        end
                    end
                end
            end

            // CORDIC vectoring, one rotation per stage
            for (k = 0; k < NCOR; k++) begin : g_cor
                if (k == 0) begin : g_first
                    always_ff @(posedge i_clk) begin
                        if (ce) begin
                            r_co[0][l] <= cor_step('{
                                x: $signed({4'd0, r_nm[NNRM-1][l].m}),
                                y: $signed({4'd0, r_nm[NNRM-1][l].v}),
                                acc: 32'sd0}, k);
                        end
                    end
                end else begin : g_rest
                    always_ff @(posedge i_clk) begin
                        if (ce) begin
                            r_co[k][l] <= cor_step(r_co[k-1][l], k);
                        end
                    end
                end
            end

            // round to Q8.8, clamp, resolve special cases
            always_comb begin
                logic signed [32:0] rnd;
                logic        [16:0] mag;
                rnd = {r_co[NCOR-1][l].acc[31], r_co[NCOR-1][l].acc} + 33'sd32768;
                mag = rnd[32:16];
                if (r_co[NCOR-1][l].acc[31]) begin
                    ang[l] = 16'd0;
                end else if (mag > 17'(ANG90)) begin
                    ang[l] = 16'(ANG90);
                end else begin
                    ang[l] = mag[15:0];
                end
                if (r_side[NST-1][l].nzero) begin
                    ang[l] = 16'd0;
                end else if (r_side[NST-1][l].szero) begin
                    ang[l] = 16'(ANG90);
                end
            end
        end
    endgenerate

    // apply signs; pitch is the negated angle
    always_comb begin
        n_res.roll_deg  = r_side[NST-1][0].neg ? -$signed(ang[0]) : $signed(ang[0]);
        n_res.pitch_deg = r_side[NST-1][1].neg ? $signed(ang[1]) : -$signed(ang[1]);
    end

    // two-entry output queue
    assign push = ce && r_vld[NST-1];
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : n_res;
            if (r_cnt == 2'd2 && push) begin
                r_q1 <= n_res;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= n_res;
            end else begin
                r_q1 <= n_res;
            end
        end
    end

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.roll_deg  = r_q0.roll_deg;
    assign o_out.pitch_deg = r_q0.pitch_deg;

endmodule

[sv/atu_checker.sv]
module atu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_roll,
    input logic signed [15:0] i_pitch
);
    // hold a waiting item until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // angles stay within plus or minus ninety degrees
    a_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_roll >= -16'sd23040) && (i_roll <= 16'sd23040))
        else $error("roll out of range");

    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pitch >= -16'sd23040) && (i_pitch <= 16'sd23040))
        else $error("pitch out of range");
endmodule

bind accel_tilt_angles_unit atu_checker u_atu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_roll      (o_out.roll_deg),
    .i_pitch     (o_out.pitch_deg)
);

[test/accel_tilt_angles_unit_check.sv]
module accel_tilt_angles_unit_check
    import atu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    atu_in_if      i_in,
    atu_out_if     i_out,
    output int     o_errors,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // atan(2^-i) in degrees, Q.24
    localparam longint TILT_ATAN [0:27] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7
    };
    localparam int ANGLE_RIGHT = 23040;

    t_res angles_due[$];
    int   errors = 0;

    assign o_errors  = errors;
    assign o_pending = angles_due.size();

    // floor square root of a 64-bit value, digit by digit
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res, bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    // atan2(num, |a,b|) in Q8.8 degrees
    function automatic int tilt_of(input longint num, input longint a, input longint b);
        bit              neg;
        longint unsigned an, s, m, v;
        longint          x, y, acc, r, dx, dy;
        neg = num < 0;
        an  = neg ? -num : num;
        s   = a * a + b * b;
        acc = 0;
        if (an == 0) return 0;
        if (s == 0) return neg ? -ANGLE_RIGHT : ANGLE_RIGHT;
        m = floor_root(s << 32);
        v = an << 16;
        while ((m | v) < (64'd1 << 59)) begin
            m <<= 1;
            v <<= 1;
        end
        x = m;
        y = v;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; acc = acc + TILT_ATAN[i];
            end else begin
                x = x - dx; y = y + dy; acc = acc - TILT_ATAN[i];
            end
        end
        r = (acc >= 0) ? ((acc + 32768) >>> 16) : -((-acc + 32768) >>> 16);
        if (r > ANGLE_RIGHT) r = ANGLE_RIGHT;
        if (r < 0) r = 0;
        return int'(neg ? -r : r);
    endfunction

    // predict on input, compare on output
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            want.roll_deg  = 16'(tilt_of(i_in.acc_y, i_in.acc_x, i_in.acc_z));
            want.pitch_deg = 16'(-tilt_of(i_in.acc_x, i_in.acc_y, i_in.acc_z));
            angles_due.push_back(want);
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (angles_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result roll=%0d pitch=%0d",
                             i_out.roll_deg, i_out.pitch_deg);
            end else begin
                want = angles_due.pop_front();
                if (want.roll_deg !== i_out.roll_deg
                        || want.pitch_deg !== i_out.pitch_deg) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected roll=%0d pitch=%0d, got roll=%0d pitch=%0d",
                                 want.roll_deg, want.pitch_deg,
                                 i_out.roll_deg, i_out.pitch_deg);
                end
            end
        end
    end
endmodule

[test/accel_tilt_angles_unit_test.sv]
module accel_tilt_angles_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_COUNT = 1750;
    localparam int CYCLE_LIMIT  = 400000;

    // directed samples: zero vector, zero magnitudes, extremes, diagonals
    localparam logic [15:0] DIR_X [0:19] = '{16'h0000, 16'h0000, 16'h0000, 16'h0005,
        16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000,
        16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0001, 16'h4000, 16'h0000, 16'h1234};
    localparam logic [15:0] DIR_Y [0:19] = '{16'h0000, 16'h0007, 16'hFFF9, 16'h0000,
        16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'h8000,
        16'h4000, 16'h4000, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hEDCC};
    localparam logic [15:0] DIR_Z [0:19] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
        16'h4000, 16'h0000, 16'h8000, 16'h0001, 16'h0000, 16'h4000, 16'h0001, 16'h5555};

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   cycles = 0;

    atu_in_if  in_ch();
    atu_out_if out_ch();

    accel_tilt_angles_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    accel_tilt_angles_unit_check checker_u (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_out    (out_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] axis_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            3: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // present one sample and hold it until taken
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        in_ch.valid <= 1'b1;
        in_ch.acc_x <= x;
        in_ch.acc_y <= y;
        in_ch.acc_z <= z;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** accel_tilt_angles_unit: FAILED **");
            $finish;
        end
    end

    // result side stalls
    initial begin
        int g;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            g = gap_len();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        int i;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.acc_x  = '0;
        in_ch.acc_y  = '0;
        in_ch.acc_z  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, zero magnitudes, extremes, diagonals
        for (i = 0; i < 20; i++) begin
            send_sample(DIR_X[i], DIR_Y[i], DIR_Z[i]);
            idle_input(gap_len());
        end

        // random, with one full drain part way through
        for (i = 0; i < SAMPLE_COUNT; i++) begin
            if (i == SAMPLE_COUNT / 2) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            send_sample(axis_value(), axis_value(), axis_value());
            if (i % 300 < 60) begin
                // run back to back
            end else begin
                idle_input(gap_len());
            end
        end
        in_ch.valid <= 1'b0;

        // drain, then let the pipeline settle
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("** accel_tilt_angles_unit: PASSED **");
        end else begin
            $display("** accel_tilt_angles_unit: FAILED **");
        end
        $finish;
    end
endmodule
